@@ src/mbt_pkg.sv @@
// Shared types, codes and constants of the multibyte character tagger.
package mbt_pkg;

    // Input item kinds
    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_EOL  = 1'b1;

    // Result kinds
    localparam logic OUT_CHAR   = 1'b0;
    localparam logic OUT_MARKER = 1'b1;

    // Encoding modes
    localparam logic MODE_UTF8 = 1'b0;
    localparam logic MODE_GB   = 1'b1;

    // Position tags
    localparam logic [1:0] TAG_B = 2'd0;
    localparam logic [1:0] TAG_I = 2'd1;
    localparam logic [1:0] TAG_E = 2'd2;

    // Byte classes
    localparam logic [7:0] BYTE_TAB    = 8'h09;
    localparam logic [7:0] BYTE_SPACE  = 8'h20;
    localparam logic [7:0] UTF8_CONT   = 8'h80;
    localparam logic [7:0] UTF8_LEAD2  = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3  = 8'hE0;
    localparam logic [7:0] UTF8_LEAD4  = 8'hF0;
    localparam logic [7:0] GB_LEAD_LO  = 8'hA1;
    localparam logic [7:0] GB_LEAD_HI  = 8'hF7;

    // Default depth of the queue between front and back (power of two)
    localparam int QUEUE_DEPTH_DEF = 4;

    // One result item, without the last flag
    typedef struct packed {
        logic        out_kind;
        logic [23:0] char_bytes;
        logic [1:0]  char_len;
        logic [1:0]  tag;
    } t_res;

    // Results caused by one input item: one or two
    typedef struct packed {
        logic two;
        t_res res0;
        t_res res1;
    } t_entry;

    function automatic t_res mk_res(input logic kind, input logic [23:0] bytes,
                                    input logic [1:0] len, input logic [1:0] tag);
        t_res r;
        r.out_kind   = kind;
        r.char_bytes = bytes;
        r.char_len   = len;
        r.tag        = tag;
        return r;
    endfunction

endpackage

@@ src/multibyte_char_bie_tagger_unit.sv @@
// Top level of the multibyte character B/I/E tagger.
//
// Slave stream: one beat per input item. tuser = kind (0 text byte, 1 end of
// line), tdata[7:0] = text byte. Master stream: one beat per result.
// tuser = out_kind (0 character, 1 sentence marker), tdata packs char_bytes,
// char_len and tag, tlast marks the final result of one input item.
// i_cfg_we/i_cfg_wdata write the encoding mode (0 UTF-8, 1 GB double-byte);
// write it only while the block is idle. o_s_tready is low during the write.
// Throughput: one input byte per cycle while the queue has room; the front
// updates the token state with each accepted beat. The output register sends
// one beat per cycle while the receiver is ready, so a two-result item holds
// the output for both beats; the queue absorbs that. Results pass through the
// queue and the output register. Items with no result leave the stream untouched.
// Reset clears the token state and selects UTF-8; no clearing pass is needed.
// When the receiver stalls the output beat holds; once the queue is full
// o_s_tready drops until a slot frees.
module multibyte_char_bie_tagger_unit
    import mbt_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] text_byte
    input  logic        i_s_tuser,   // [0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [23:0] char_bytes, [25:24] char_len, [27:26] tag
    output logic        o_m_tuser,   // [0] out_kind
    output logic        o_m_tlast
);

    logic   push;
    t_entry wentry;
    logic   pop;
    t_entry rentry;
    logic   full;
    logic   empty;
    t_res   res;

    mbt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_kind      (i_s_tuser),
        .i_byte      (i_s_tdata),
        .i_full      (full),
        .o_push      (push),
        .o_entry     (wentry)
    );

    mbt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (wentry),
        .i_pop   (pop),
        .o_rdata (rentry),
        .o_full  (full),
        .o_empty (empty)
    );

    mbt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_rdata (rentry),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (res),
        .o_last  (o_m_tlast)
    );

    // Output beat packing
    assign o_m_tdata = {4'd0, res.tag, res.char_len, res.char_bytes};
    assign o_m_tuser = res.out_kind;

endmodule

@@ src/mbt_front.sv @@
// Front end: byte classification, character assembly and tagging.
module mbt_front
    import mbt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_kind,
    input  logic [7:0] i_byte,
    input  logic       i_full,
    output logic       o_push,
    output t_entry     o_entry
);

    logic        r_mode,   n_mode;
    logic [23:0] r_pbytes, n_pbytes;
    logic [1:0]  r_pcount, n_pcount;
    logic [1:0]  r_pneed,  n_pneed;
    logic [23:0] r_hchar,  n_hchar;
    logic [1:0]  r_hlen,   n_hlen;
    logic        r_hfirst, n_hfirst;
    logic        r_skip,   n_skip;

    logic        accept;
    logic [1:0]  v_cnt;
    t_res        v_res0;
    t_res        v_res1;
    t_res        v_new;
    logic [1:0]  v_tag;
    logic [23:0] v_cbytes;

    // no beat is taken while the mode register is written
    assign o_ready = !i_full && !i_cfg_we;
    assign accept  = i_valid && o_ready;

    // Next state and results of the accepted beat
    always_comb begin
        n_mode   = r_mode;
        n_pbytes = r_pbytes;
        n_pcount = r_pcount;
        n_pneed  = r_pneed;
        n_hchar  = r_hchar;
        n_hlen   = r_hlen;
        n_hfirst = r_hfirst;
        n_skip   = r_skip;
        v_cnt    = 2'd0;
        v_res0   = '0;
        v_res1   = '0;
        v_new    = '0;
        v_tag    = TAG_B;
        v_cbytes = '0;

        if (i_cfg_we) begin
            // mode write drops a character being assembled
            n_mode   = i_cfg_wdata;
            n_pbytes = '0;
            n_pcount = 2'd0;
            n_pneed  = 2'd0;
        end else if (accept) begin
            if (i_kind == KIND_EOL || i_byte == BYTE_TAB || i_byte == BYTE_SPACE) begin
                // token end: flush held char, or a lone GB lead byte
                v_tag = r_hfirst ? TAG_B : TAG_E;
                if (r_hlen != 2'd0) begin
                    v_res0 = mk_res(OUT_CHAR, r_hchar, r_hlen, v_tag);
                    v_cnt  = 2'd1;
                end else if (r_mode == MODE_GB && r_pcount == 2'd1 && !r_skip) begin
                    v_res0 = mk_res(OUT_CHAR, r_pbytes, 2'd1, v_tag);
                    v_cnt  = 2'd1;
                end
                n_pbytes = '0;
                n_pcount = 2'd0;
                n_pneed  = 2'd0;
                n_hchar  = '0;
                n_hlen   = 2'd0;
                n_hfirst = 1'b0;
                n_skip   = 1'b0;
                if (i_kind == KIND_EOL) begin
                    v_new = mk_res(OUT_MARKER, 24'd0, 2'd0, TAG_B);
                    if (v_cnt == 2'd0) begin
                        v_res0 = v_new;
                    end else begin
                        v_res1 = v_new;
                    end
                    v_cnt = v_cnt + 2'd1;
                end
            end else if (!r_skip) begin
                if (r_mode == MODE_UTF8) begin
                    if (r_pcount == 2'd0) begin
                        if (i_byte < UTF8_CONT) begin
                            // ASCII: complete at once
                            if (r_hlen == 2'd0) begin
                                n_hfirst = 1'b1;
                            end
                            if (r_hlen != 2'd0) begin
                                v_res0   = mk_res(OUT_CHAR, r_hchar, r_hlen,
                                                  n_hfirst ? TAG_B : TAG_I);
                                v_cnt    = 2'd1;
                                n_hfirst = 1'b0;
                            end
                            n_hchar = {i_byte, 16'd0};
                            n_hlen  = 2'd1;
                        end else if (i_byte < UTF8_LEAD2 || i_byte >= UTF8_LEAD4) begin
                            // stray continuation or unsupported lead
                            n_skip = 1'b1;
                        end else begin
                            if (r_hlen == 2'd0) begin
                                n_hfirst = 1'b1;
                            end
                            n_pbytes = {i_byte, 16'd0};
                            n_pcount = 2'd1;
                            n_pneed  = (i_byte < UTF8_LEAD3) ? 2'd2 : 2'd3;
                        end
                    end else if ((i_byte & UTF8_LEAD2) != UTF8_CONT) begin
                        // bad continuation byte
                        n_pbytes = '0;
                        n_pcount = 2'd0;
                        n_pneed  = 2'd0;
                        n_skip   = 1'b1;
                    end else begin
                        v_cbytes = r_pbytes | ((r_pcount == 2'd1) ? {8'd0, i_byte, 8'd0}
                                                                  : {16'd0, i_byte});
                        if (r_pcount + 2'd1 >= r_pneed) begin
                            if (r_hlen != 2'd0) begin
                                v_res0   = mk_res(OUT_CHAR, r_hchar, r_hlen,
                                                  r_hfirst ? TAG_B : TAG_I);
                                v_cnt    = 2'd1;
                                n_hfirst = 1'b0;
                            end
                            n_hchar  = v_cbytes;
                            n_hlen   = r_pneed;
                            n_pbytes = '0;
                            n_pcount = 2'd0;
                            n_pneed  = 2'd0;
                        end else begin
                            n_pbytes = v_cbytes;
                            n_pcount = r_pcount + 2'd1;
                        end
                    end
                end else begin
                    if (r_pcount == 2'd0) begin
                        if (i_byte >= GB_LEAD_LO && i_byte <= GB_LEAD_HI) begin
                            // lead byte: held char cannot be the last one
                            if (r_hlen != 2'd0) begin
                                v_res0   = mk_res(OUT_CHAR, r_hchar, r_hlen,
                                                  r_hfirst ? TAG_B : TAG_I);
                                v_cnt    = 2'd1;
                                n_hfirst = 1'b0;
                                n_hchar  = '0;
                                n_hlen   = 2'd0;
                            end else begin
                                n_hfirst = 1'b1;
                            end
                            n_pbytes = {i_byte, 16'd0};
                            n_pcount = 2'd1;
                            n_pneed  = 2'd2;
                        end else begin
                            if (r_hlen == 2'd0) begin
                                n_hfirst = 1'b1;
                            end
                            if (r_hlen != 2'd0) begin
                                v_res0   = mk_res(OUT_CHAR, r_hchar, r_hlen,
                                                  n_hfirst ? TAG_B : TAG_I);
                                v_cnt    = 2'd1;
                                n_hfirst = 1'b0;
                            end
                            n_hchar = {i_byte, 16'd0};
                            n_hlen  = 2'd1;
                        end
                    end else begin
                        // trail byte completes the double-byte char
                        if (r_hlen != 2'd0) begin
                            v_res0   = mk_res(OUT_CHAR, r_hchar, r_hlen,
                                              r_hfirst ? TAG_B : TAG_I);
                            v_cnt    = 2'd1;
                            n_hfirst = 1'b0;
                        end
                        n_hchar  = r_pbytes | {8'd0, i_byte, 8'd0};
                        n_hlen   = 2'd2;
                        n_pbytes = '0;
                        n_pcount = 2'd0;
                        n_pneed  = 2'd0;
                    end
                end
            end
        end
    end

    assign o_push        = accept && !i_cfg_we && (v_cnt != 2'd0);
    assign o_entry.two   = (v_cnt == 2'd2);
    assign o_entry.res0  = v_res0;
    assign o_entry.res1  = v_res1;

    // Tokenizer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_UTF8;
            r_pbytes <= '0;
            r_pcount <= 2'd0;
            r_pneed  <= 2'd0;
            r_hchar  <= '0;
            r_hlen   <= 2'd0;
            r_hfirst <= 1'b0;
            r_skip   <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_pbytes <= n_pbytes;
            r_pcount <= n_pcount;
            r_pneed  <= n_pneed;
            r_hchar  <= n_hchar;
            r_hlen   <= n_hlen;
            r_hfirst <= n_hfirst;
            r_skip   <= n_skip;
        end
    end

endmodule

@@ src/mbt_queue.sv @@
// Short register queue of result entries between front and back.
module mbt_queue
    import mbt_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_wdata,
    input  logic   i_pop,
    output t_entry o_rdata,
    output logic   o_full,
    output logic   o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wptr, n_wptr;
    logic [AW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointers wrap at the last slot
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        if (do_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
        end
        n_count = r_count + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

@@ src/mbt_back.sv @@
// Back end: output register that sends one or two result beats per entry.
module mbt_back
    import mbt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_empty,
    input  t_entry i_rdata,
    output logic   o_pop,
    output logic   o_valid,
    input  logic   i_ready,
    output t_res   o_res,
    output logic   o_last
);

    logic   r_valid, n_valid;
    logic   r_sel,   n_sel;
    t_entry r_ent,   n_ent;
    logic   cur_last;
    logic   load;

    assign cur_last = r_sel || !r_ent.two;
    assign load     = !i_empty && (!r_valid || (i_ready && cur_last));
    assign o_pop    = load;
    assign o_valid  = r_valid;
    assign o_res    = r_sel ? r_ent.res1 : r_ent.res0;
    assign o_last   = cur_last;

    // Advance within an entry, or take the next one
    always_comb begin
        n_valid = r_valid;
        n_sel   = r_sel;
        n_ent   = r_ent;
        if (load) begin
            n_valid = 1'b1;
            n_sel   = 1'b0;
            n_ent   = i_rdata;
        end else if (r_valid && i_ready) begin
            if (cur_last) begin
                n_valid = 1'b0;
                n_sel   = 1'b0;
            end else begin
                n_sel = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sel   <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    // A first beat of a pair is always followed by its second
    a_pair_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_ready && !cur_last) |=> (r_valid && r_sel))
        else $error("second beat of a pair missing");

    // The second slot is only shown for two-result entries
    a_sel_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_sel) |-> r_ent.two)
        else $error("second slot shown for single-result entry");

    // A stalled beat keeps its slot
    a_stall_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_sel)))
        else $error("slot changed under stall");

endmodule

@@ sim/tb_multibyte_char_bie_tagger_unit.sv @@
// Self-checking testbench for the multibyte character B/I/E tagger.
module tb_multibyte_char_bie_tagger_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mbt_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 400;
    localparam int IDLE_LIMIT     = 2000;
    localparam int PHASE_ITEMS    = 275;
    localparam int N_PHASES       = 6;
    localparam int MAX_REPORTS    = 10;
    // encoding mode per random phase, phase 0 in bit 0
    localparam logic [N_PHASES-1:0] PHASE_MODES = 6'b101100;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic        out_kind;
        logic [23:0] char_bytes;
        logic [1:0]  char_len;
        logic [1:0]  tag;
        logic        last_flag;
    } t_tagged;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata   = 8'h00;  // [7:0] text_byte
    logic        i_s_tuser   = 1'b0;   // [0] kind
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [31:0] o_m_tdata;            // [23:0] char_bytes, [25:24] char_len, [27:26] tag
    logic        o_m_tuser;            // [0] out_kind
    logic        o_m_tlast;

    multibyte_char_bie_tagger_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_item   text_q[$];     // items waiting to be sent
    t_tagged tagged_q[$];   // tagged characters and markers still to come
    t_tagged step_out[$];   // results of the item being predicted
    int      n_fail = 0;
    logic    want_hold = 1'b0;

    // Tokenizer state of the predictor
    logic        cur_mode;
    logic [23:0] asm_bytes;
    logic [1:0]  asm_cnt;
    logic [1:0]  asm_need;
    logic [23:0] hold_char;
    logic [1:0]  hold_len;
    logic        hold_first;
    logic        drop_rest;

    function automatic void put_result(logic k, logic [23:0] b, logic [1:0] l,
                                       logic [1:0] t);
        t_tagged r;
        r = '{k, b, l, t, 1'b0};
        step_out.insert(step_out.size(), r);
    endfunction

    function automatic void clear_asm();
        asm_bytes = '0;
        asm_cnt   = '0;
        asm_need  = '0;
    endfunction

    // held character is known not to end its token
    function automatic void release_held();
        put_result(OUT_CHAR, hold_char, hold_len, hold_first ? TAG_B : TAG_I);
        hold_first = 1'b0;
        hold_len   = '0;
        hold_char  = '0;
    endfunction

    function automatic void open_char();
        if (hold_len == 0) hold_first = 1'b1;
    endfunction

    function automatic void finish_char(logic [23:0] b, logic [1:0] l);
        if (hold_len != 0) release_held();
        hold_char = b;
        hold_len  = l;
    endfunction

    function automatic void close_token();
        logic [1:0] t;
        t = hold_first ? TAG_B : TAG_E;
        if (hold_len != 0) begin
            put_result(OUT_CHAR, hold_char, hold_len, t);
        end else if (cur_mode == MODE_GB && asm_cnt == 2'd1 && !drop_rest) begin
            // lone GB lead at token end stands as a one-byte character
            put_result(OUT_CHAR, asm_bytes, 2'd1, t);
        end
        clear_asm();
        hold_char  = '0;
        hold_len   = '0;
        hold_first = 1'b0;
        drop_rest  = 1'b0;
    endfunction

    function automatic void utf8_step(logic [7:0] b);
        if (asm_cnt == 0) begin
            if (b < UTF8_CONT) begin
                open_char();
                finish_char({b, 16'h0000}, 2'd1);
            end else if (b < UTF8_LEAD2) begin
                drop_rest = 1'b1;           // stray continuation
            end else if (b < UTF8_LEAD4) begin
                open_char();
                asm_bytes = {b, 16'h0000};
                asm_cnt   = 2'd1;
                asm_need  = (b < UTF8_LEAD3) ? 2'd2 : 2'd3;
            end else begin
                drop_rest = 1'b1;           // 4-byte lead or invalid lead
            end
        end else if (b[7:6] != 2'b10) begin
            clear_asm();
            drop_rest = 1'b1;
        end else begin
            if (asm_cnt == 2'd1) asm_bytes[15:8] = b;
            else asm_bytes[7:0] = b;
            asm_cnt = asm_cnt + 2'd1;
            if (asm_cnt >= asm_need) begin
                finish_char(asm_bytes, asm_need);
                clear_asm();
            end
        end
    endfunction

    function automatic void gb_step(logic [7:0] b);
        if (asm_cnt == 0) begin
            if (b >= GB_LEAD_LO && b <= GB_LEAD_HI) begin
                // another character surely follows, so the held one goes now
                if (hold_len != 0) release_held();
                else hold_first = 1'b1;
                asm_bytes = {b, 16'h0000};
                asm_cnt   = 2'd1;
                asm_need  = 2'd2;
            end else begin
                open_char();
                finish_char({b, 16'h0000}, 2'd1);
            end
        end else begin
            finish_char({asm_bytes[23:16], b, 8'h00}, 2'd2);
            clear_asm();
        end
    endfunction

    function automatic void tag_item(t_item it);
        step_out.delete();
        if (it.kind == KIND_EOL) begin
            close_token();
            put_result(OUT_MARKER, 24'h0, 2'd0, TAG_B);
        end else if (it.data == BYTE_TAB || it.data == BYTE_SPACE) begin
            close_token();
        end else if (!drop_rest) begin
            if (cur_mode == MODE_UTF8) utf8_step(it.data);
            else gb_step(it.data);
        end
        if (step_out.size() != 0) step_out[$].last_flag = 1'b1;
        tagged_q = {tagged_q, step_out};
    endfunction

    function automatic void reset_tokenizer();
        cur_mode   = MODE_UTF8;
        clear_asm();
        hold_char  = '0;
        hold_len   = '0;
        hold_first = 1'b0;
        drop_rest  = 1'b0;
    endfunction

    // Stimulus builders
    function automatic void push_item(logic k, logic [7:0] d);
        t_item it;
        it = '{k, d};
        text_q.insert(text_q.size(), it);
    endfunction

    function automatic void push_utf8_char();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            push_item(KIND_TEXT, 8'($urandom_range(0, 8'h7F)));
        end else if (sel < 68) begin
            push_item(KIND_TEXT, 8'($urandom_range(8'hC0, 8'hDF)));
            push_item(KIND_TEXT, 8'($urandom_range(8'h80, 8'hBF)));
        end else if (sel < 90) begin
            push_item(KIND_TEXT, 8'($urandom_range(8'hE0, 8'hEF)));
            push_item(KIND_TEXT, 8'($urandom_range(8'h80, 8'hBF)));
            push_item(KIND_TEXT, 8'($urandom_range(8'h80, 8'hBF)));
        end else if (sel < 95) begin
            // lead followed by an arbitrary byte, mostly a bad continuation
            push_item(KIND_TEXT, 8'($urandom_range(8'hC0, 8'hEF)));
            push_item(KIND_TEXT, 8'($urandom_range(0, 255)));
        end else begin
            push_item(KIND_TEXT, 8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void push_gb_char();
        if ($urandom_range(0, 99) < 45) begin
            push_item(KIND_TEXT, 8'($urandom_range(0, 8'hA0)));
        end else if ($urandom_range(0, 19) == 0) begin
            push_item(KIND_TEXT, 8'($urandom_range(8'hF8, 8'hFF)));
        end else begin
            push_item(KIND_TEXT, 8'($urandom_range(GB_LEAD_LO, GB_LEAD_HI)));
            push_item(KIND_TEXT, 8'($urandom_range(0, 255)));
        end
    endfunction

    // a lead byte left open at the token end
    function automatic void push_cut_char(logic m);
        if (m == MODE_GB) begin
            push_item(KIND_TEXT, 8'($urandom_range(GB_LEAD_LO, GB_LEAD_HI)));
        end else begin
            push_item(KIND_TEXT, 8'($urandom_range(8'hE0, 8'hEF)));
            if ($urandom_range(0, 1) == 1)
                push_item(KIND_TEXT, 8'($urandom_range(8'h80, 8'hBF)));
        end
    endfunction

    function automatic void push_random_line(logic m);
        int n_tok;
        int n_ch;
        n_tok = $urandom_range(1, 6);
        for (int t = 0; t < n_tok; t++) begin
            n_ch = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            for (int c = 0; c < n_ch; c++) begin
                if (m == MODE_UTF8) push_utf8_char();
                else push_gb_char();
            end
            if ($urandom_range(0, 9) == 0) push_cut_char(m);
            if (t < n_tok - 1 || $urandom_range(0, 1) == 1) begin
                push_item(KIND_TEXT, $urandom_range(0, 1) ? BYTE_SPACE : BYTE_TAB);
                if ($urandom_range(0, 5) == 0) push_item(KIND_TEXT, BYTE_SPACE);
            end
        end
        push_item(KIND_EOL, 8'($urandom_range(0, 255)));
    endfunction

    function automatic string fmt_tagged(t_tagged r);
        return $sformatf("kind=%0d bytes=%06h len=%0d tag=%0d last=%0d",
                         r.out_kind, r.char_bytes, r.char_len, r.tag, r.last_flag);
    endfunction

    function automatic void log_failure(string msg);
        n_fail++;
        if (n_fail <= MAX_REPORTS) $display("ERROR: %s", msg);
    endfunction

    // Sender: bursts of beats with random gaps, predicts on acceptance
    t_item cur_item;
    int    burst_left = 0;
    int    gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) tag_item(cur_item);
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_s_tvalid <= 1'b0;
                end else if (text_q.size() != 0) begin
                    cur_item = text_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tuser  <= cur_item.kind;
                    i_s_tdata  <= cur_item.data;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: four stall patterns taken in turn, plus one long hold-off
    logic [31:0] rdy_cycle = '0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            rdy_cycle <= rdy_cycle + 1;
            if (hold_left != 0) begin
                hold_left  <= hold_left - 1;
                i_m_tready <= 1'b0;
            end else if (want_hold && !hold_done) begin
                hold_left  <= LONG_HOLD;
                hold_done  <= 1'b1;
                i_m_tready <= 1'b0;
            end else begin
                case (rdy_cycle[8:7])
                    2'd0: i_m_tready <= 1'b1;
                    2'd1: i_m_tready <= 1'($urandom_range(0, 1));
                    2'd2: i_m_tready <= (rdy_cycle[1:0] == 2'd0);
                    default: i_m_tready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_tagged got;
        t_tagged want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{o_m_tuser, o_m_tdata[23:0], o_m_tdata[25:24], o_m_tdata[27:26],
                    o_m_tlast};
            if (tagged_q.size() == 0) begin
                log_failure({"unexpected beat: ", fmt_tagged(got)});
            end else begin
                want = tagged_q.pop_front();
                if (got !== want)
                    log_failure({"expected ", fmt_tagged(want), " got ", fmt_tagged(got)});
            end
        end
    end

    // Watchdog on cycles without any accepted beat
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("multibyte_char_bie_tagger_unit test failed");
            $finish;
        end
    end

    task automatic wait_drained();
        do @(negedge i_clk);
        while (text_q.size() != 0 || i_s_tvalid || tagged_q.size() != 0);
        // items without results may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(logic m);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_mode = m;
        clear_asm();
    endtask

    initial begin
        logic [7:0] seq[$];
        logic       m;
        reset_tokenizer();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // UTF-8: multi-byte chars, zero byte, empty token, stray and bad
        // continuations, 4-byte lead, sequence cut by end of line
        write_mode(MODE_UTF8);
        seq = '{8'h00, 8'hC3, 8'hA9, 8'hE4, 8'hB8, 8'hAD, 8'h20, 8'h20,
                8'h7F, 8'h80, 8'h09, 8'h61, 8'hC3, 8'h41, 8'h20, 8'hF0, 8'h20,
                8'h62, 8'hE4, 8'hB8};
        foreach (seq[i]) push_item(KIND_TEXT, seq[i]);
        push_item(KIND_EOL, 8'hFF);
        // leave a held char and an open sequence across the mode change
        push_item(KIND_TEXT, 8'h63);
        push_item(KIND_TEXT, 8'hC3);
        wait_drained();

        // GB: lead right after a held char, pair extremes, lead at token end
        write_mode(MODE_GB);
        seq = '{8'hA1, 8'hFF, 8'h20, 8'hF7, 8'hA0, 8'hA1, 8'h09};
        foreach (seq[i]) push_item(KIND_TEXT, seq[i]);
        push_item(KIND_EOL, 8'h00);
        wait_drained();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            m = PHASE_MODES[ph];
            write_mode(m);
            if (ph == 1) want_hold = 1'b1;
            while (text_q.size() < PHASE_ITEMS) push_random_line(m);
            // end the phase inside a token
            if (m == MODE_UTF8) push_utf8_char();
            else push_gb_char();
            if ($urandom_range(0, 1) == 1) push_cut_char(m);
            wait_drained();
        end

        if (n_fail == 0) begin
            $display("multibyte_char_bie_tagger_unit test passed");
        end else begin
            $display("multibyte_char_bie_tagger_unit test failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/mbt_pkg.sv
src/mbt_front.sv
src/mbt_queue.sv
src/mbt_back.sv
src/multibyte_char_bie_tagger_unit.sv
sim/tb_multibyte_char_bie_tagger_unit.sv
